// ----- design/qrs_pkg.sv -----
// qrs_pkg: shared widths, status codes, queue item type and the per-step
// functions of the square root and divider pipelines
// no dependencies
package qrs_pkg;

   localparam int COEF_W   = 16;
   localparam int FRAC     = 16;
   localparam int ROOT_W   = 40;
   localparam int PROD_W   = 2 * COEF_W;
   localparam int DELTA_W  = 2 * COEF_W + 3;          // signed discriminant
   localparam int D_W      = 2 * COEF_W + 2;          // discriminant magnitude, even
   localparam int SQ_STEPS = D_W / 2 + FRAC;          // one root bit per step
   localparam int S_W      = SQ_STEPS;
   localparam int SQR_W    = S_W + 3;                 // partial remainder
   localparam int BASE_W   = COEF_W + FRAC + 1;
   localparam int NUM_W    = S_W + 2;                 // signed numerator
   localparam int DEN_W    = COEF_W + 1;              // |2a|
   localparam int DIV_STEPS = NUM_W;
   localparam int Q_DEPTH  = 4;
   localparam int Q_AW     = $clog2(Q_DEPTH);

   localparam logic [1:0] ST_NONE   = 2'd0;
   localparam logic [1:0] ST_DOUBLE = 2'd1;
   localparam logic [1:0] ST_TWO    = 2'd2;
   localparam logic [1:0] ST_AZERO  = 2'd3;

   typedef struct packed {
      logic [1:0]               status;
      logic [D_W-1:0]           delta;
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
   } item_type;

   typedef struct packed {
      logic [SQR_W-1:0] rem;
      logic [S_W-1:0]   root;
   } sq_state_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] quo;
   } div_state_type;

   // one restoring square root digit
   function automatic sq_state_type sq_step(sq_state_type cur, logic [1:0] pair);
      logic [SQR_W-1:0] r;
      logic [SQR_W-1:0] trial;
      sq_state_type     nxt;
      r     = {cur.rem[SQR_W-3:0], pair};
      trial = {1'b0, cur.root, 2'b01};
      if (r >= trial) begin
         nxt.rem  = r - trial;
         nxt.root = {cur.root[S_W-2:0], 1'b1};
      end else begin
         nxt.rem  = r;
         nxt.root = {cur.root[S_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // one restoring division bit, numerator shifts out as quotient shifts in
   function automatic div_state_type div_step(div_state_type cur, logic [DEN_W-1:0] den);
      logic [DEN_W:0] r;
      div_state_type  nxt;
      r = {cur.rem, cur.quo[NUM_W-1]};
      if (r >= {1'b0, den}) begin
         r       = r - {1'b0, den};
         nxt.quo = {cur.quo[NUM_W-2:0], 1'b1};
      end else begin
         nxt.quo = {cur.quo[NUM_W-2:0], 1'b0};
      end
      nxt.rem = r[DEN_W-1:0];
      return nxt;
   endfunction

endpackage

// ----- design/qrs_front.sv -----
// qrs_front: registers the products of the coefficients, forms the
// discriminant and classifies the item; depends on qrs_pkg
module qrs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [qrs_pkg::COEF_W-1:0] req_coef_a,
   input  logic [qrs_pkg::COEF_W-1:0] req_coef_b,
   input  logic [qrs_pkg::COEF_W-1:0] req_coef_c,
   output logic                       push,
   output qrs_pkg::item_type          push_item,
   input  logic                       q_full
);
   import qrs_pkg::*;

   logic                       s1_valid_ff, s1_valid_in;
   logic signed [COEF_W-1:0]   a_ff, b_ff;
   logic signed [PROD_W-1:0]   bb_ff, ac_ff;
   logic signed [DELTA_W-1:0]  delta;

   assign req_stall   = s1_valid_ff && q_full;
   assign push        = s1_valid_ff && !q_full;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         a_ff  <= signed'(req_coef_a);
         b_ff  <= signed'(req_coef_b);
         bb_ff <= signed'(req_coef_b) * signed'(req_coef_b);
         ac_ff <= signed'(req_coef_a) * signed'(req_coef_c);
      end
   end

   assign delta = DELTA_W'(bb_ff) - (DELTA_W'(ac_ff) <<< 2);

   always_comb begin
      push_item.coef_a = a_ff;
      push_item.coef_b = b_ff;
      push_item.delta  = delta[D_W-1:0];
      if (a_ff == '0) begin
         push_item.status = ST_AZERO;
      end else if (delta[DELTA_W-1]) begin
         push_item.status = ST_NONE;
      end else if (delta == '0) begin
         push_item.status = ST_DOUBLE;
      end else begin
         push_item.status = ST_TWO;
      end
   end

endmodule

// ----- design/qrs_queue.sv -----
// qrs_queue: short fifo between front and back
// depends on qrs_pkg
module qrs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qrs_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output qrs_pkg::item_type head
);
   import qrs_pkg::*;

   item_type         mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_AW:0]    cnt_ff, cnt_in;
   logic             do_pop;

   assign full   = (cnt_ff == (Q_AW+1)'(Q_DEPTH));
   assign empty  = (cnt_ff == '0);
   assign do_pop = pop && !empty;
   assign head   = mem_ff[rd_ff];
   assign wr_in  = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ----- design/qrs_back.sv -----
// qrs_back: pipelined square root, two pipelined dividers and the result
// register; depends on qrs_pkg
module qrs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  qrs_pkg::item_type                head,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_root_status,
   output logic signed [qrs_pkg::ROOT_W-1:0] rsp_root_low,
   output logic signed [qrs_pkg::ROOT_W-1:0] rsp_root_high
);
   import qrs_pkg::*;

   logic         adv;
   logic         out_valid_ff;

   // square root stages
   logic         sv_ff [SQ_STEPS+1];
   item_type     si_ff [SQ_STEPS+1];
   logic [D_W-1:0] sd_ff [SQ_STEPS+1];
   sq_state_type ss_ff [SQ_STEPS+1];

   // divider stages, lane 0 minus branch, lane 1 plus branch
   logic          dv_ff   [DIV_STEPS+1];
   logic [1:0]    dst_ff  [DIV_STEPS+1];
   logic [DEN_W-1:0] dden_ff [DIV_STEPS+1];
   logic          dneg_ff [2][DIV_STEPS+1];
   div_state_type ds_ff   [2][DIV_STEPS+1];

   logic signed [BASE_W-1:0] base;
   logic signed [NUM_W-1:0]  s_w;
   logic signed [NUM_W-1:0]  num [2];
   logic [COEF_W-1:0]        a_abs;
   logic signed [ROOT_W-1:0] root_w [2];

   assign adv = !out_valid_ff || !rsp_stall;
   assign pop = adv && !q_empty;

   // prep for the dividers from the last root stage
   always_comb begin
      base   = -(BASE_W'(si_ff[SQ_STEPS].coef_b)) <<< FRAC;
      s_w    = {2'b00, ss_ff[SQ_STEPS].root};
      num[0] = NUM_W'(base) - s_w;
      num[1] = NUM_W'(base) + s_w;
      a_abs  = si_ff[SQ_STEPS].coef_a[COEF_W-1] ? COEF_W'(-si_ff[SQ_STEPS].coef_a)
                                                : COEF_W'(si_ff[SQ_STEPS].coef_a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQ_STEPS; k++) begin
            sv_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= !q_empty;
         for (int k = 1; k <= SQ_STEPS; k++) begin
            sv_ff[k] <= sv_ff[k-1];
         end
         dv_ff[0] <= sv_ff[SQ_STEPS];
         for (int k = 1; k <= DIV_STEPS; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         out_valid_ff <= dv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         si_ff[0]      <= head;
         sd_ff[0]      <= head.delta;
         ss_ff[0].rem  <= '0;
         ss_ff[0].root <= '0;
         for (int k = 1; k <= SQ_STEPS; k++) begin
            si_ff[k] <= si_ff[k-1];
            sd_ff[k] <= {sd_ff[k-1][D_W-3:0], 2'b00};
            ss_ff[k] <= sq_step(ss_ff[k-1], sd_ff[k-1][D_W-1:D_W-2]);
         end

         dst_ff[0]  <= si_ff[SQ_STEPS].status;
         dden_ff[0] <= {a_abs, 1'b0};
         for (int l = 0; l < 2; l++) begin
            dneg_ff[l][0]    <= num[l][NUM_W-1] ^ si_ff[SQ_STEPS].coef_a[COEF_W-1];
            ds_ff[l][0].rem  <= '0;
            ds_ff[l][0].quo  <= num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
         end
         for (int k = 1; k <= DIV_STEPS; k++) begin
            dst_ff[k]  <= dst_ff[k-1];
            dden_ff[k] <= dden_ff[k-1];
            for (int l = 0; l < 2; l++) begin
               dneg_ff[l][k] <= dneg_ff[l][k-1];
               ds_ff[l][k]   <= div_step(ds_ff[l][k-1], dden_ff[k-1]);
            end
         end

         rsp_root_status <= dst_ff[DIV_STEPS];
         rsp_root_low    <= root_w[0];
         rsp_root_high   <= root_w[1];
      end
   end

   // sign the quotients, no real root and zero a give zero roots
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (dst_ff[DIV_STEPS] == ST_DOUBLE || dst_ff[DIV_STEPS] == ST_TWO) begin
            root_w[l] = dneg_ff[l][DIV_STEPS] ? -ROOT_W'(ds_ff[l][DIV_STEPS].quo)
                                              : ROOT_W'(ds_ff[l][DIV_STEPS].quo);
         end else begin
            root_w[l] = '0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- design/quadratic_root_solver.sv -----
// quadratic_root_solver: real roots of a*x^2 + b*x + c in signed 24.16 fixed point
// throughput one transfer per cycle when nothing stalls, carried by the 33-step root
// pipeline and the 35-step divider pipelines that all advance together
// reset (synchronous, active high) clears valid bits, queue pointers and queue count only
// depends on qrs_pkg, qrs_front, qrs_queue, qrs_back
module quadratic_root_solver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_c,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_root_status,
   output logic signed [qrs_pkg::ROOT_W-1:0] rsp_root_low,
   output logic signed [qrs_pkg::ROOT_W-1:0] rsp_root_high
);
   import qrs_pkg::*;

   // front to queue
   logic     push;
   item_type push_item;
   logic     q_full;
   // queue to back
   logic     q_empty;
   logic     pop;
   item_type head;

   // front: product stage, then discriminant and class on the way into the queue
   qrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_coef_a (req_coef_a),
      .req_coef_b (req_coef_b),
      .req_coef_c (req_coef_c),
      .push       (push),
      .push_item  (push_item),
      .q_full     (q_full)
   );

   // decoupling queue, the front only stalls when it is full
   qrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head      (head)
   );

   // back: square root, two dividers, result register; the whole pipe
   // advances whenever the result register is free or being drained
   qrs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_root_status (rsp_root_status),
      .rsp_root_low    (rsp_root_low),
      .rsp_root_high   (rsp_root_high)
   );

   // no root and zero a always report zero roots
   a_zero_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_status == ST_NONE || rsp_root_status == ST_AZERO)
      |-> rsp_root_low == '0 && rsp_root_high == '0)
      else $error("nonzero root with no real root");

   // a double root has both branches equal
   a_double_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_status == ST_DOUBLE |-> rsp_root_low == rsp_root_high)
      else $error("double root branches differ");

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("queue overflow");

   // a stalled result keeps its valid and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root_status)
      && $stable(rsp_root_low) && $stable(rsp_root_high))
      else $error("result changed while stalled");

endmodule
